/* rtl/button_click_event_detector_core_assert.svh */
// assertion macros for the button click event detector core
// used by the top level only, no other dependencies
`ifndef BUTTON_CLICK_EVENT_DETECTOR_CORE_ASSERT_SVH
`define BUTTON_CLICK_EVENT_DETECTOR_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// checked outside reset only
`define BCED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked during reset too
`define BCED_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define BCED_ASSERT(lbl, prop, msg)
`define BCED_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* rtl/bced_pkg.sv */
// shared types and constants of the button click event detector
// no dependencies
package bced_pkg;

  localparam int unsigned LANES_MAX = 8;
  localparam int unsigned OPT_W     = 4;

  // option bit positions inside one lane's nibble
  localparam int unsigned OPT_CLICK  = 0;
  localparam int unsigned OPT_DOUBLE = 1;
  localparam int unsigned OPT_LONG   = 2;
  localparam int unsigned OPT_HOLD   = 3;

  typedef enum logic [3:0] {
    REG_DEBOUNCE      = 4'd0,
    REG_SHORT_CLICK   = 4'd1,
    REG_LONG_CLICK    = 4'd2,
    REG_LONG_RELEASE  = 4'd3,
    REG_DOUBLE_CLICK  = 4'd4,
    REG_POLARITY      = 4'd5,
    REG_OPTIONS       = 4'd6,
    REG_ACTIVE_COUNT  = 4'd7
  } reg_idx_e;

  // timing thresholds shared by all lanes
  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] short_click_ms;
    logic [15:0] long_click_ms;
    logic [15:0] long_release_ms;
    logic [15:0] double_click_ms;
  } timing_cfg_t;

  // events of one lane for one poll
  typedef struct packed {
    logic click;
    logic dbl;
    logic lng;
    logic hold;
  } lane_evt_t;

endpackage

/* rtl/bced_cfg.sv */
// configuration register file of the button click event detector
// depends on bced_pkg
module bced_cfg import bced_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [3:0]                  cfg_index_i,
  input  logic [31:0]                 cfg_data_i,
  output timing_cfg_t                 timing_o,
  output logic [LANES_MAX-1:0]        polarity_o,
  output logic [OPT_W*LANES_MAX-1:0]  options_o,
  output logic [3:0]                  active_count_o
);

  timing_cfg_t                timing_q;
  logic [LANES_MAX-1:0]       polarity_q;
  logic [OPT_W*LANES_MAX-1:0] options_q;
  logic [3:0]                 active_count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timing_q.debounce_ms     <= 16'd20;
      timing_q.short_click_ms  <= 16'd300;
      timing_q.long_click_ms   <= 16'd1000;
      timing_q.long_release_ms <= 16'd1000;
      timing_q.double_click_ms <= 16'd300;
      polarity_q               <= '0;
      options_q                <= '0;
      active_count_q           <= 4'd8;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_DEBOUNCE:     timing_q.debounce_ms     <= cfg_data_i[15:0];
        REG_SHORT_CLICK:  timing_q.short_click_ms  <= cfg_data_i[15:0];
        REG_LONG_CLICK:   timing_q.long_click_ms   <= cfg_data_i[15:0];
        REG_LONG_RELEASE: timing_q.long_release_ms <= cfg_data_i[15:0];
        REG_DOUBLE_CLICK: timing_q.double_click_ms <= cfg_data_i[15:0];
        REG_POLARITY:     polarity_q               <= cfg_data_i[LANES_MAX-1:0];
        REG_OPTIONS:      options_q                <= cfg_data_i[OPT_W*LANES_MAX-1:0];
        REG_ACTIVE_COUNT: active_count_q           <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign timing_o       = timing_q;
  assign polarity_o     = polarity_q;
  assign options_o      = options_q;
  assign active_count_o = active_count_q;

endmodule

/* rtl/bced_lane.sv */
// one button lane: debounce, press timing, click counting and hold flag
// depends on bced_pkg
module bced_lane import bced_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic             prime_i,
  input  logic             en_i,
  input  logic [31:0]      now_i,
  input  logic             pin_i,
  input  logic             pol_i,
  input  logic [OPT_W-1:0] opt_i,
  input  timing_cfg_t      timing_i,
  output lane_evt_t        evt_o
);

  logic        stable_q, stable_d;
  logic [31:0] change_q, change_d;
  logic [31:0] press_q, press_d;
  logic        listen_q, listen_d;
  logic [1:0]  count_q, count_d;
  logic [31:0] start_q, start_d;
  logic        armed_q, armed_d;
  logic        holding_q, holding_d;

  logic [31:0] since_change, press_age, since_listen;
  logic [16:0] wait_ms;
  logic [15:0] hold_thr;
  logic        stable_n;

  assign since_change = now_i - change_q;
  assign press_age    = now_i - press_q;
  assign stable_n     = (since_change >= {16'b0, timing_i.debounce_ms}) ? pin_i : stable_q;
  assign wait_ms      = {1'b0, timing_i.short_click_ms}
                      + (opt_i[OPT_DOUBLE] ? {1'b0, timing_i.double_click_ms} : 17'd0);
  assign hold_thr     = opt_i[OPT_LONG] ? timing_i.long_release_ms : timing_i.short_click_ms;
  // a window opened by this poll starts now
  assign since_listen = listen_q ? (now_i - start_q) : 32'd0;

  always_comb begin
    stable_d  = stable_q;
    change_d  = change_q;
    press_d   = press_q;
    listen_d  = listen_q;
    count_d   = count_q;
    start_d   = start_q;
    armed_d   = armed_q;
    holding_d = holding_q;
    evt_o     = '0;
    if (prime_i) begin
      stable_d = pin_i;
    end else if (en_i) begin
      stable_d = stable_n;
      if (stable_n != stable_q) begin
        change_d = now_i;
        if (stable_n == pol_i) begin
          press_d = now_i;
        end else begin
          holding_d = 1'b0;
          armed_d   = 1'b1;
          if (press_age <= {16'b0, timing_i.short_click_ms}) begin
            if (!listen_q) begin
              listen_d = 1'b1;
              start_d  = now_i;
            end
            if (count_q != 2'd3) count_d = count_q + 2'd1;
          end else if (press_age < {16'b0, timing_i.long_release_ms} && opt_i[OPT_HOLD]) begin
            evt_o.lng = opt_i[OPT_LONG];
          end
        end
      end else begin
        // level steady: long click or hold while pressed
        if (!opt_i[OPT_HOLD]) begin
          if (stable_q == pol_i && press_age > {16'b0, timing_i.long_click_ms} && armed_q) begin
            evt_o.lng = opt_i[OPT_LONG];
            armed_d   = 1'b0;
          end
        end else if (stable_q == pol_i && press_age > {16'b0, hold_thr}) begin
          holding_d = 1'b1;
        end
      end
      // close the listening window
      if (listen_d) begin
        if (since_listen > {15'b0, wait_ms} || !opt_i[OPT_DOUBLE] || count_d > 2'd1) begin
          listen_d = 1'b0;
          if (count_d == 2'd1) begin
            evt_o.click = opt_i[OPT_CLICK];
          end else if (count_d > 2'd1) begin
            evt_o.dbl = opt_i[OPT_DOUBLE];
          end
          count_d = 2'd0;
        end
      end
      evt_o.hold = holding_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q  <= 1'b0;
      change_q  <= '0;
      press_q   <= '0;
      listen_q  <= 1'b0;
      count_q   <= '0;
      start_q   <= '0;
      armed_q   <= 1'b1;
      holding_q <= 1'b0;
    end else if (take_i) begin
      stable_q  <= stable_d;
      change_q  <= change_d;
      press_q   <= press_d;
      listen_q  <= listen_d;
      count_q   <= count_d;
      start_q   <= start_d;
      armed_q   <= armed_d;
      holding_q <= holding_d;
    end
  end

endmodule

/* rtl/button_click_event_detector_core.sv */
// top level of the button click event detector: poll register, lanes, result register
// depends on bced_pkg, bced_cfg, bced_lane and the assertion macro header
//
//  channel  direction  handshake                 payload
//  in       input      in_valid_i / in_ready_o   now_ms_i, pin_levels_i
//  out      output     out_valid_o / out_ready_i click, double click, long click, hold masks
//  cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one poll per cycle while results are taken: an input transfer fills the poll register,
// which feeds the lane logic, which updates lane state and fills the result register
// rst_ni clears all lane state and loads the register defaults, the first poll
// after reset only adopts the pin levels and reports all zero
// a stalled result holds in the result register, one more poll waits in the poll
// register, then in_ready_o drops; config writes are taken every cycle
`include "button_click_event_detector_core_assert.svh"

module button_click_event_detector_core import bced_pkg::*; #(
  parameter int unsigned NUM_BUTTONS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [31:0]          now_ms_i,
  input  logic [LANES_MAX-1:0] pin_levels_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [LANES_MAX-1:0] click_mask_o,
  output logic [LANES_MAX-1:0] double_click_mask_o,
  output logic [LANES_MAX-1:0] long_click_mask_o,
  output logic [LANES_MAX-1:0] hold_mask_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [3:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  // configuration
  timing_cfg_t                timing;
  logic [LANES_MAX-1:0]       polarity;
  logic [OPT_W*LANES_MAX-1:0] options;
  logic [3:0]                 active_count;

  bced_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .timing_o       (timing),
    .polarity_o     (polarity),
    .options_o      (options),
    .active_count_o (active_count)
  );

  // poll register
  logic                 poll_valid_q;
  logic [31:0]          poll_now_q;
  logic [LANES_MAX-1:0] poll_pins_q;
  logic                 primed_q;
  logic                 advance;

  // result register
  logic                 res_valid_q;
  logic [LANES_MAX-1:0] click_q, dbl_q, lng_q, hold_q;

  // poll moves into the result register when that one is free or being drained
  assign advance    = poll_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !poll_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      poll_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      poll_now_q  <= now_ms_i;
      poll_pins_q <= pin_levels_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q <= 1'b0;
    end else if (advance) begin
      primed_q <= 1'b1;
    end
  end

  // lanes, unbuilt lanes report nothing
  lane_evt_t            evt [LANES_MAX];
  logic [LANES_MAX-1:0] lane_active;

  for (genvar i = 0; i < LANES_MAX; i++) begin : g_lane
    if (i < NUM_BUTTONS) begin : g_used
      localparam logic [3:0] LaneIdx = 4'(i);
      // counts above the lane total simply enable every lane
      assign lane_active[i] = active_count > LaneIdx;

      bced_lane u_lane (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .take_i   (advance),
        .prime_i  (!primed_q),
        .en_i     (lane_active[i]),
        .now_i    (poll_now_q),
        .pin_i    (poll_pins_q[i]),
        .pol_i    (polarity[i]),
        .opt_i    (options[OPT_W*i +: OPT_W]),
        .timing_i (timing),
        .evt_o    (evt[i])
      );
    end else begin : g_unused
      assign lane_active[i] = 1'b0;
      assign evt[i]         = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int i = 0; i < LANES_MAX; i++) begin
        click_q[i] <= evt[i].click;
        dbl_q[i]   <= evt[i].dbl;
        lng_q[i]   <= evt[i].lng;
        hold_q[i]  <= evt[i].hold;
      end
    end
  end

  assign out_valid_o         = res_valid_q;
  assign click_mask_o        = click_q;
  assign double_click_mask_o = dbl_q;
  assign long_click_mask_o   = lng_q;
  assign hold_mask_o         = hold_q;

  // checks
  `BCED_ASSERT_ALWAYS(a_ready_when_empty, !res_valid_q |-> in_ready_o, "poll stalled with empty result register")
  `BCED_ASSERT(a_first_poll_quiet, advance && !primed_q |=> ((click_q | dbl_q | lng_q | hold_q) == '0), "first poll after reset reported events")
  `BCED_ASSERT(a_inactive_quiet, out_valid_o |-> (((click_q | dbl_q | lng_q | hold_q) & ~lane_active) == '0), "inactive lane reported an event")
  `BCED_ASSERT(a_click_excl, out_valid_o |-> ((click_q & dbl_q) == '0), "click and double click on one lane")

endmodule
